[src/pve_pkg.sv]
// ============================================================================
// Prefix varint encoder package
// Field widths, length codes and the tag constants of the prefix encoding.
// ============================================================================
`default_nettype none

package pve_pkg;

   localparam int unsigned ValueWidth = 64;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned MaxBytes   = 10;
   localparam int unsigned WordWidth  = MaxBytes * ByteWidth;
   localparam int unsigned CountWidth = $clog2(MaxBytes + 1);

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [WordWidth-1:0]  word_type;

   // Number of bytes in each form of the encoding.
   localparam count_type LenOne   = count_type'(1);
   localparam count_type LenTwo   = count_type'(2);
   localparam count_type LenFour  = count_type'(4);
   localparam count_type LenEight = count_type'(8);
   localparam count_type LenLong  = count_type'(10);

   // Length prefixes in the first byte's low bits; LongHeader fills two bytes.
   localparam logic [1:0]  PrefixTwo   = 2'b01;
   localparam logic [2:0]  PrefixFour  = 3'b011;
   localparam logic [3:0]  PrefixEight = 4'b0111;
   localparam logic [15:0] LongHeader  = 16'h000F;

endpackage : pve_pkg

`default_nettype wire

[src/prefix_varint_encoder_top.sv]
// ============================================================================
// Prefix varint encoder
// Encodes an unsigned 64-bit value as a little-endian prefix varint of
// 1, 2, 4, 8 or 10 bytes, one byte per beat, with the final byte flagged.
//
//   Channel | Direction | Beat contents
//   --------+-----------+--------------------------------------
//   req     | in        | req_value, 64-bit unsigned
//   rsp     | out       | rsp_out_byte, rsp_last
//
// A value is first held in the input register and is then shifted out of the
// byte register at one byte per cycle while rsp is not stalled, so a value
// spans 1, 2, 4, 8 or 10 bytes; the byte register sets the sustained rate.
// The next value is taken into the input register while the previous one is
// still being sent, and follows its last byte without a gap.
// Reset is synchronous and empties both registers.
// A stall on rsp holds the current byte; req is stalled only while the input
// register is full and cannot move on.
// ============================================================================
`default_nettype none

module prefix_varint_encoder_top
   import pve_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ValueWidth-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ByteWidth-1:0]       rsp_out_byte,
   output logic                       rsp_last
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [ValueWidth-1:0] value_ff;
   count_type             count_ff;
   count_type             count_in;
   word_type              word_ff;
   word_type              word_in;
   word_type              enc_word;
   count_type             enc_len;
   logic                  req_accept;
   logic                  rsp_accept;
   logic                  out_free;
   logic                  load_out;

   always_comb begin
      if (value_ff[ValueWidth-1:7] == '0) begin
         enc_word = word_type'({value_ff[6:0], 1'b0});
         enc_len  = LenOne;
      end else if (value_ff[ValueWidth-1:14] == '0) begin
         enc_word = word_type'({value_ff[13:0], PrefixTwo});
         enc_len  = LenTwo;
      end else if (value_ff[ValueWidth-1:29] == '0) begin
         enc_word = word_type'({value_ff[28:0], PrefixFour});
         enc_len  = LenFour;
      end else if (value_ff[ValueWidth-1:60] == '0) begin
         enc_word = word_type'({value_ff[59:0], PrefixEight});
         enc_len  = LenEight;
      end else begin
         enc_word = {value_ff, LongHeader};
         enc_len  = LenLong;
      end
   end

   assign rsp_valid    = (count_ff != '0);
   assign rsp_out_byte = word_ff[ByteWidth-1:0];
   assign rsp_last     = (count_ff == count_type'(1));
   assign rsp_accept   = rsp_valid && !rsp_stall;

   assign out_free   = !rsp_valid || (rsp_accept && rsp_last);
   assign load_out   = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !load_out;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      count_in    = count_ff;
      word_in     = word_ff;
      if (load_out) begin
         in_valid_in = 1'b0;
         count_in    = enc_len;
         word_in     = enc_word;
      end else if (rsp_accept) begin
         count_in = count_ff - count_type'(1);
         word_in  = {{ByteWidth{1'b0}}, word_ff[WordWidth-1:ByteWidth]};
      end
      if (req_accept) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (req_accept) begin
         value_ff <= req_value;
      end
   end

endmodule : prefix_varint_encoder_top

`default_nettype wire
